[rtl/core/slr_pkg.sv]
// Shared types, constants and divider helpers for the slew rate limiter.
`default_nettype none

package slr_pkg;

	// Credit divisor: rate is per minute, elapsed time in milliseconds
	localparam logic [31:0] CREDIT_DIV = 32'd60000;
	// floor(2^48 / 60000), estimate of a 16-bit quotient digit is low by at most one
	localparam logic [32:0] RECIP_M = 33'd4691249611;
	// product stage plus two stages for each of four 16-bit quotient digits
	localparam int DIV_STAGES = 9;

	localparam int CFG_AW = 4;

	localparam logic [1:0] REG_HOLD_TIME = 2'd0;
	localparam logic [1:0] REG_MAX_RISE  = 2'd1;
	localparam logic [1:0] REG_MAX_FALL  = 2'd2;

	typedef struct packed {
		logic [31:0] hold_time_ms;
		logic [31:0] max_rise_per_minute;
		logic [31:0] max_fall_per_minute;
	} cfg_t;

	typedef struct packed {
		logic [31:0] elapsed_ms;
		logic [31:0] requested_target;
		logic        pressure_active;
		logic        emergency_drain;
	} item_t;

	// quo saturates at 2^32 (bit 32 set means "at least 2^32")
	typedef struct packed {
		logic [32:0] quo;
		logic [15:0] rem;
	} credit_t;

	typedef struct packed {
		logic [15:0] q;
		logic [15:0] r;
	} digit_t;

	function automatic logic [15:0] recip_est(input logic [31:0] x);
		logic [64:0] p;
		p = {33'b0, x} * {32'b0, RECIP_M};
		return p[63:48];
	endfunction

	// correct the estimated digit and form the remainder
	function automatic digit_t digit_fix(input logic [31:0] x, input logic [15:0] qe);
		digit_t      d;
		logic [31:0] t;
		t = x - ({16'b0, qe} * CREDIT_DIV);
		if (t >= CREDIT_DIV) begin
			d.q = qe + 16'd1;
			d.r = 16'(t - CREDIT_DIV);
		end else begin
			d.q = qe;
			d.r = t[15:0];
		end
		return d;
	endfunction

endpackage

`default_nettype wire

[rtl/core/slr_cfg.sv]
// APB register file for hold time and rise/fall rates.
`default_nettype none

module slr_cfg import slr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_time_ms        <= 32'd0;
			cfg_q.max_rise_per_minute <= 32'd1;
			cfg_q.max_fall_per_minute <= 32'd1;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_HOLD_TIME: cfg_q.hold_time_ms        <= pwdata;
				REG_MAX_RISE:  cfg_q.max_rise_per_minute <= pwdata;
				REG_MAX_FALL:  cfg_q.max_fall_per_minute <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_HOLD_TIME: prdata = cfg_q.hold_time_ms;
			REG_MAX_RISE:  prdata = cfg_q.max_rise_per_minute;
			REG_MAX_FALL:  prdata = cfg_q.max_fall_per_minute;
			default:       prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/slr_credit_div.sv]
// Credit pipeline: elapsed * rate, then divide by 60000 one 16-bit digit at a time.
`default_nettype none

module slr_credit_div import slr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [31:0] elapsed_ms,
	input  wire logic [31:0] rate,
	output credit_t          credit
);

	localparam int NDIG = 4;

	logic [63:0] mult_s1;
	logic [31:0] rate_eff;

	logic [63:0] dig_prod [0:NDIG];
	logic [15:0] dig_rem  [0:NDIG];
	logic [63:0] dig_quo  [0:NDIG];

	// a rate of zero counts as one
	assign rate_eff = (rate == 32'd0) ? 32'd1 : rate;

	always_ff @(posedge clk) begin
		if (en) begin
			mult_s1 <= {32'b0, elapsed_ms} * {32'b0, rate_eff};
		end
	end

	assign dig_prod[0] = mult_s1;
	assign dig_rem[0]  = 16'd0;
	assign dig_quo[0]  = 64'd0;

	for (genvar d = 0; d < NDIG; d++) begin : g_digit
		localparam int HI = 63 - 16 * d;

		logic [31:0] x_s1;
		logic [15:0] qe_s1;
		logic [63:0] prod_s1;
		logic [63:0] quo_s1;
		logic [63:0] prod_s2;
		logic [63:0] quo_s2;
		logic [15:0] rem_s2;
		logic [31:0] x_in;
		digit_t      fix;

		assign x_in = {dig_rem[d], dig_prod[d][HI -: 16]};
		assign fix  = digit_fix(x_s1, qe_s1);

		// estimate the digit by reciprocal multiply
		always_ff @(posedge clk) begin
			if (en) begin
				x_s1    <= x_in;
				qe_s1   <= recip_est(x_in);
				prod_s1 <= dig_prod[d];
				quo_s1  <= dig_quo[d];
			end
		end

		// fix the digit by one compare and subtract
		always_ff @(posedge clk) begin
			if (en) begin
				prod_s2 <= prod_s1;
				quo_s2  <= {quo_s1[47:0], fix.q};
				rem_s2  <= fix.r;
			end
		end

		assign dig_prod[d+1] = prod_s2;
		assign dig_quo[d+1]  = quo_s2;
		assign dig_rem[d+1]  = rem_s2;
	end

	assign credit.quo = (dig_quo[NDIG][63:32] != 32'd0) ? {1'b1, 32'd0}
	                                                    : {1'b0, dig_quo[NDIG][31:0]};
	assign credit.rem = dig_rem[NDIG];

endmodule

`default_nettype wire

[rtl/core/slr_step.sv]
// State stage: hold countdown, credit remainders, limited target and result register.
`default_nettype none

module slr_step import slr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        vin,
	input  wire item_t       item,
	input  wire credit_t     rise,
	input  wire credit_t     fall,
	input  wire logic [31:0] hold_time_ms,
	output logic             out_valid,
	output logic [31:0]      smoothed_target,
	output logic [31:0]      requested_echo,
	output logic             recovery_held,
	output logic             rise_limited,
	output logic             fall_limited
);

	logic [31:0] cur_val_q;
	logic [31:0] hold_q;
	logic [15:0] rise_rem_q;
	logic [15:0] fall_rem_q;
	logic        started_q;
	logic        out_valid_q;

	logic [31:0] cur, hold_b, hold_n, cur_n;
	logic [15:0] rrem_b, frem_b, rrem_n, frem_n;
	logic [16:0] rsum, fsum, rwrap, fwrap;
	logic        rcarry, fcarry;
	logic [32:0] rbud33, fbud33;
	logic [31:0] rbud, fbud, up_gap, dn_gap;
	logic        held, rlim, flim;
	logic [31:0] req, el;

	assign req = item.requested_target;
	assign el  = item.elapsed_ms;

	always_comb begin
		// first request loads the target and starts from clean state
		cur    = started_q ? cur_val_q  : req;
		hold_b = started_q ? hold_q     : 32'd0;
		rrem_b = started_q ? rise_rem_q : 16'd0;
		frem_b = started_q ? fall_rem_q : 16'd0;

		if (item.pressure_active) begin
			hold_n = hold_time_ms;
		end else if (hold_b > el) begin
			hold_n = hold_b - el;
		end else begin
			hold_n = 32'd0;
		end

		rsum   = {1'b0, rrem_b} + {1'b0, rise.rem};
		rcarry = rsum >= CREDIT_DIV[16:0];
		rwrap  = rcarry ? rsum - CREDIT_DIV[16:0] : rsum;
		rbud33 = rise.quo + {32'd0, rcarry};
		rbud   = rbud33[32] ? 32'hFFFF_FFFF : rbud33[31:0];

		fsum   = {1'b0, frem_b} + {1'b0, fall.rem};
		fcarry = fsum >= CREDIT_DIV[16:0];
		fwrap  = fcarry ? fsum - CREDIT_DIV[16:0] : fsum;
		fbud33 = fall.quo + {32'd0, fcarry};
		fbud   = fbud33[32] ? 32'hFFFF_FFFF : fbud33[31:0];

		up_gap = req - cur;
		dn_gap = cur - req;

		cur_n  = cur;
		rrem_n = rrem_b;
		frem_n = frem_b;
		held   = 1'b0;
		rlim   = 1'b0;
		flim   = 1'b0;

		if (req > cur) begin
			if (hold_n != 32'd0) begin
				held = 1'b1;
			end else begin
				rrem_n = rwrap[15:0];
				if (up_gap > rbud) begin
					cur_n = cur + rbud;
					rlim  = 1'b1;
				end else begin
					cur_n = req;
				end
			end
		end else if (req < cur) begin
			if (item.emergency_drain) begin
				// drop at once and forget fall credit
				cur_n  = req;
				frem_n = 16'd0;
			end else begin
				frem_n = fwrap[15:0];
				if (dn_gap > fbud) begin
					cur_n = cur - fbud;
					flim  = 1'b1;
				end else begin
					cur_n = req;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_val_q   <= 32'd0;
			hold_q      <= 32'd0;
			rise_rem_q  <= 16'd0;
			fall_rem_q  <= 16'd0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vin;
			if (vin) begin
				cur_val_q  <= cur_n;
				hold_q     <= hold_n;
				rise_rem_q <= rrem_n;
				fall_rem_q <= frem_n;
				started_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && vin) begin
			smoothed_target <= cur_n;
			requested_echo  <= req;
			recovery_held   <= held;
			rise_limited    <= rlim;
			fall_limited    <= flim;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_rise_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		rise_rem_q < CREDIT_DIV[15:0]) else $error("rise remainder out of range");

	a_fall_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		fall_rem_q < CREDIT_DIV[15:0]) else $error("fall remainder out of range");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $countones({recovery_held, rise_limited, fall_limited}) <= 1)
		else $error("more than one limit flag set");

	a_rise_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && rise_limited |-> smoothed_target < requested_echo)
		else $error("rise limited but target reached");

	a_fall_short: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && fall_limited |-> smoothed_target > requested_echo)
		else $error("fall limited but target reached");
`endif

endmodule

`default_nettype wire

[rtl/core/slew_rate_limiter_with_hold_unit.sv]
// Top level of the slew rate limiter with recovery hold.
`default_nettype none

// Takes one request per clock unless stalled and returns one result per request, in
// order. A request passes the credit pipeline (elapsed*rate multiply, then a divide by
// 60000, one 16-bit quotient digit per two stages), then the state stage, which updates
// the hold countdown, remainders and target and loads the result register. A stall on
// the result side while a result is valid freezes the whole pipeline and shows on
// in_stall in the same cycle. Configuration must be written over APB (hold time at 0x0,
// rise rate at 0x4, fall rate at 0x8) only while no request is in flight (not enforced).
module slew_rate_limiter_with_hold_unit import slr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [CFG_AW-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [31:0]       elapsed_ms,
	input  wire logic [31:0]       requested_target,
	input  wire logic              pressure_active,
	input  wire logic              emergency_drain,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [31:0]            smoothed_target,
	output logic [31:0]            requested_echo,
	output logic                   recovery_held,
	output logic                   rise_limited,
	output logic                   fall_limited
);

	cfg_t    cfg;
	credit_t rise_credit;
	credit_t fall_credit;
	item_t   item_in;
	logic    adv;

	logic  vld_s  [1:DIV_STAGES];
	item_t item_s [1:DIV_STAGES];

	slr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// hold everything while a finished result is stalled
	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	assign item_in.elapsed_ms       = elapsed_ms;
	assign item_in.requested_target = requested_target;
	assign item_in.pressure_active  = pressure_active;
	assign item_in.emergency_drain  = emergency_drain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= DIV_STAGES; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int i = 2; i <= DIV_STAGES; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s[1] <= item_in;
			for (int i = 2; i <= DIV_STAGES; i++) begin
				item_s[i] <= item_s[i-1];
			end
		end
	end

	slr_credit_div u_rise_div (
		.clk        (clk),
		.en         (adv),
		.elapsed_ms (elapsed_ms),
		.rate       (cfg.max_rise_per_minute),
		.credit     (rise_credit)
	);

	slr_credit_div u_fall_div (
		.clk        (clk),
		.en         (adv),
		.elapsed_ms (elapsed_ms),
		.rate       (cfg.max_fall_per_minute),
		.credit     (fall_credit)
	);

	slr_step u_step (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (adv),
		.vin             (vld_s[DIV_STAGES]),
		.item            (item_s[DIV_STAGES]),
		.rise            (rise_credit),
		.fall            (fall_credit),
		.hold_time_ms    (cfg.hold_time_ms),
		.out_valid       (out_valid),
		.smoothed_target (smoothed_target),
		.requested_echo  (requested_echo),
		.recovery_held   (recovery_held),
		.rise_limited    (rise_limited),
		.fall_limited    (fall_limited)
	);

endmodule

`default_nettype wire
